// ===== hw/rtl/rqbt_pkg.sv =====
// shared types, register codes and error table helper for the read quality trimmer
package rqbt_pkg;

  // field widths of the transfers
  localparam int unsigned QUAL_W   = 7;
  localparam int unsigned START_W  = 10;
  localparam int unsigned KEEP_W   = 11;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned ESUM_W   = 43;
  localparam int unsigned CUTOFF_W = 32;
  localparam int unsigned MINLEN_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // every code a 7-bit quality difference can take
  localparam int unsigned QUAL_CODES = 1 << QUAL_W;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERROR_CUTOFF  = 2'd0,
    CFG_QUALITY_SHIFT = 2'd1,
    CFG_MIN_KEEP_LEN  = 2'd2
  } cfg_reg_t;

  // register reset values
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 32'd4294967;
  localparam logic [QUAL_W-1:0]   SHIFT_RST  = 7'd33;
  localparam logic [MINLEN_W-1:0] MINLEN_RST = 11'd75;

  typedef struct packed {
    logic              base_is_n;
    logic [QUAL_W-1:0] quality;
    logic              last_base;
  } in_item_t;

  typedef struct packed {
    logic [START_W-1:0] keep_start;
    logic [KEEP_W-1:0]  keep_length;
    logic               was_trimmed;
    logic               too_short;
    logic [LEN_W-1:0]   read_length;
    logic [ESUM_W-1:0]  error_sum;
    logic               read_overflow;
  } out_item_t;

  // 10^(-j/10) scaled by 10^15
  localparam logic [63:0] DEC_ONE = 64'd1000000000000000;
  localparam logic [63:0] ROOT_TAB [10] = '{
    64'd1000000000000000, 64'd794328234724282, 64'd630957344480193,
    64'd501187233627272,  64'd398107170553497, 64'd316227766016838,
    64'd251188643150958,  64'd199526231496888, 64'd158489319246111,
    64'd125892541179417
  };

  // error probability 10^(-k/10) with frac_bits fractional bits, rounded half up
  function automatic logic [63:0] err_rom_entry(input int unsigned k,
                                                input int unsigned frac_bits);
    logic [63:0] den;
    logic [63:0] half;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] q;
    logic [3:0]  j;
    int unsigned d;
    d    = k / 10;
    j    = 4'(k % 10);
    den  = 64'd1;
    half = 64'd0;
    for (int unsigned i = 0; i < d; i++) begin
      half = den * 64'd5;
      den  = den * 64'd10;
    end
    num = ROOT_TAB[j] + half;
    // restoring division by the decade
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    // decimal fraction to binary fraction
    q = quo / DEC_ONE;
    r = quo % DEC_ONE;
    for (int unsigned i = 0; i < frac_bits; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= DEC_ONE) begin
        r    = r - DEC_ONE;
        q[0] = 1'b1;
      end
    end
    if ({r[62:0], 1'b0} >= DEC_ONE) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

// ===== hw/rtl/read_quality_block_trimmer.sv =====
// read quality trimmer: per-base error accumulation, block split and per-read result
//
// Bases of a read arrive one per transfer on the in_ channel, one every cycle when
// nothing stalls. Each base's quality (an N base counts as quality zero) is looked
// up in a constant error table and added into a whole-read sum and a running block
// sum; a base whose block sum exceeds the block's allowance closes the block and is
// itself left out. On the last base one result leaves on the out_ channel: the
// whole read, or its longest block when the read's error exceeds cutoff times
// length (ties to the earlier block), with keep_length zero and too_short set when
// the kept part is shorter than the configured minimum length. Bases beyond
// MAX_READ_LEN are ignored and flag read_overflow. The datapath is four registers
// deep (input, table lookup, finish record, result); the accumulate stage, one
// saturating add and compare per base, sets the rate of one base per cycle when
// nothing stalls. A waiting result holds up only the last base of the next read,
// and only while the finish record is full too. Configuration is written through
// cfg_we/cfg_index and takes effect at once; write it only while no read is in
// flight. No clearing pass is needed after reset.
module read_quality_block_trimmer #(
  parameter int unsigned MAX_READ_LEN  = 1024,
  parameter int unsigned ERR_FRAC_BITS = 32,
  parameter int unsigned QUAL_LEVELS   = 100
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // base transfers
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rqbt_pkg::in_item_t                  in_data,
  // result transfers
  output logic                                out_valid,
  input  logic                                out_stall,
  output rqbt_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [rqbt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rqbt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // position width holds MAX_READ_LEN itself
  localparam int unsigned PW     = $clog2(MAX_READ_LEN + 1);
  // error table entry, entry zero is exactly 1.0
  localparam int unsigned EW     = ERR_FRAC_BITS + 1;
  // sums never pass MAX_READ_LEN entries of at most 1.0; capped at 64 bits
  localparam int unsigned SW_RAW = ERR_FRAC_BITS + $clog2(MAX_READ_LEN) + 1;
  localparam int unsigned SW     = (SW_RAW > 64) ? 64 : SW_RAW;
  localparam int unsigned MINLEN_W = rqbt_pkg::MINLEN_W;
  localparam int unsigned CW     = (PW > MINLEN_W) ? PW : MINLEN_W;
  localparam int unsigned QUAL_W = rqbt_pkg::QUAL_W;
  localparam int unsigned CUTOFF_W = rqbt_pkg::CUTOFF_W;
  localparam int unsigned START_W = rqbt_pkg::START_W;
  localparam int unsigned KEEP_W  = rqbt_pkg::KEEP_W;
  localparam int unsigned LEN_W   = rqbt_pkg::LEN_W;
  localparam int unsigned ESUM_W  = rqbt_pkg::ESUM_W;
  localparam int unsigned ASH     = (ERR_FRAC_BITS >= 32) ? ERR_FRAC_BITS - 32
                                                          : 32 - ERR_FRAC_BITS;

  // saturating add, saturation only reachable at the 64-bit cap
  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] x,
                                            input logic [SW-1:0] y);
    logic [SW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[SW] ? {SW{1'b1}} : s[SW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CUTOFF_W-1:0] cfg_cutoff_r;
  logic [QUAL_W-1:0]   cfg_shift_r;
  logic [MINLEN_W-1:0] cfg_min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cutoff_r  <= rqbt_pkg::CUTOFF_RST;
      cfg_shift_r   <= rqbt_pkg::SHIFT_RST;
      cfg_min_len_r <= rqbt_pkg::MINLEN_RST;
    end else if (cfg_we) begin
      case (rqbt_pkg::cfg_reg_t'(cfg_index))
        rqbt_pkg::CFG_ERROR_CUTOFF:  cfg_cutoff_r  <= cfg_wdata[CUTOFF_W-1:0];
        rqbt_pkg::CFG_QUALITY_SHIFT: cfg_shift_r   <= cfg_wdata[QUAL_W-1:0];
        rqbt_pkg::CFG_MIN_KEEP_LEN:  cfg_min_len_r <= cfg_wdata[MINLEN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // per-base allowance: the cutoff brought to the sum's fraction
  logic [SW-1:0] allow;
  if (ERR_FRAC_BITS >= 32) begin : g_allow_up
    assign allow = SW'(cfg_cutoff_r) << ASH;
  end else begin : g_allow_dn
    assign allow = SW'(cfg_cutoff_r >> ASH);
  end

  // ---------------------------------------------------------------------------
  // error table, codes at or past QUAL_LEVELS read as zero
  // ---------------------------------------------------------------------------
  logic [EW-1:0] rom_tab [rqbt_pkg::QUAL_CODES];

  for (genvar k = 0; k < rqbt_pkg::QUAL_CODES; k++) begin : g_rom
    localparam logic [63:0] ENTRY = rqbt_pkg::err_rom_entry(k, ERR_FRAC_BITS);
    assign rom_tab[k] = (k < QUAL_LEVELS) ? ENTRY[EW-1:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // stage handshake: each stage moves on when the one after it has room, so
  // bases keep flowing while a finished result waits on out_stall
  // ---------------------------------------------------------------------------
  logic in_v_r, err_v_r, fin_v_r, out_valid_r;
  logic err_last_r;
  logic out_free, fin_move, fin_free, err_go, err_free, in_go, in_free, accept;

  assign out_free = !out_valid_r || !out_stall;
  assign fin_move = fin_v_r && out_free;
  assign fin_free = !fin_v_r || out_free;
  // only a last base needs room in the finish stage
  assign err_go   = err_v_r && (!err_last_r || fin_free);
  assign err_free = !err_v_r || err_go;
  assign in_go    = in_v_r && err_free;
  assign in_free  = !in_v_r || in_go;
  assign in_stall = !in_free;
  assign accept   = in_valid && in_free;

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  rqbt_pkg::in_item_t in_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (in_go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // lookup stage: quality to error probability
  // ---------------------------------------------------------------------------
  logic [QUAL_W-1:0] qual_code;
  logic              qual_ok;
  logic [QUAL_W-1:0] rom_idx;
  logic [EW-1:0]     err_val;
  logic [EW-1:0]     err_e_r;

  assign qual_code = in_item_r.quality - cfg_shift_r;
  assign qual_ok   = in_item_r.quality >= cfg_shift_r;
  // an N base reads as quality zero
  assign rom_idx   = in_item_r.base_is_n ? '0 : qual_code;
  assign err_val   = (in_item_r.base_is_n || qual_ok) ? rom_tab[rom_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_v_r <= 1'b0;
    end else if (in_go) begin
      err_v_r <= 1'b1;
    end else if (err_go) begin
      err_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      err_e_r    <= err_val;
      err_last_r <= in_item_r.last_base;
    end
  end

  // ---------------------------------------------------------------------------
  // accumulate stage: read and block sums, block split, best block so far
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pos_r, bb_r, bestb_r, bestl_r;
  logic [SW-1:0] tot_r, tal_r, be_r, ba_r;
  logic          ovf_r;

  logic [PW-1:0] pos_upd, bb_upd, bestb_upd, bestl_upd;
  logic [SW-1:0] tot_upd, tal_upd, be_upd, ba_upd;
  logic          ovf_upd;

  logic [PW-1:0] pos_nxt, bb_nxt, bestb_nxt, bestl_nxt;
  logic [SW-1:0] tot_nxt, tal_nxt, be_nxt, ba_nxt;
  logic          ovf_nxt;

  logic [SW-1:0] e_ext, tot_add, tal_add, be_add, ba_add;
  logic [PW-1:0] blk_len;
  logic          in_range;
  logic          read_end;

  assign e_ext    = SW'(err_e_r);
  assign tot_add  = sat_add(tot_r, e_ext);
  assign tal_add  = sat_add(tal_r, allow);
  assign be_add   = sat_add(be_r, e_ext);
  assign ba_add   = sat_add(ba_r, allow);
  assign blk_len  = pos_r - bb_r;
  assign in_range = pos_r < PW'(MAX_READ_LEN);
  assign read_end = err_go && err_last_r;

  always_comb begin
    pos_upd   = pos_r;
    bb_upd    = bb_r;
    bestb_upd = bestb_r;
    bestl_upd = bestl_r;
    tot_upd   = tot_r;
    tal_upd   = tal_r;
    be_upd    = be_r;
    ba_upd    = ba_r;
    ovf_upd   = ovf_r;
    if (err_go) begin
      if (in_range) begin
        tot_upd = tot_add;
        tal_upd = tal_add;
        if (be_add > ba_add) begin
          // this base breaks the block and is not part of it
          if (blk_len > bestl_r) begin
            bestl_upd = blk_len;
            bestb_upd = bb_r;
          end
          bb_upd = pos_r + PW'(1);
          be_upd = '0;
          ba_upd = '0;
        end else begin
          be_upd = be_add;
          ba_upd = ba_add;
        end
        pos_upd = pos_r + PW'(1);
      end else begin
        // read too long, base dropped
        ovf_upd = 1'b1;
      end
    end
  end

  // state starts over after a read's last base
  always_comb begin
    pos_nxt   = read_end ? '0 : pos_upd;
    bb_nxt    = read_end ? '0 : bb_upd;
    bestb_nxt = read_end ? '0 : bestb_upd;
    bestl_nxt = read_end ? '0 : bestl_upd;
    tot_nxt   = read_end ? '0 : tot_upd;
    tal_nxt   = read_end ? '0 : tal_upd;
    be_nxt    = read_end ? '0 : be_upd;
    ba_nxt    = read_end ? '0 : ba_upd;
    ovf_nxt   = read_end ? 1'b0 : ovf_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      bb_r    <= '0;
      bestb_r <= '0;
      bestl_r <= '0;
      tot_r   <= '0;
      tal_r   <= '0;
      be_r    <= '0;
      ba_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      bb_r    <= bb_nxt;
      bestb_r <= bestb_nxt;
      bestl_r <= bestl_nxt;
      tot_r   <= tot_nxt;
      tal_r   <= tal_nxt;
      be_r    <= be_nxt;
      ba_r    <= ba_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // finish record: the read's totals, taken on its last base
  // ---------------------------------------------------------------------------
  logic [PW-1:0] fin_len_r, fin_bb_r, fin_bestb_r, fin_bestl_r;
  logic [SW-1:0] fin_tot_r;
  logic          fin_trim_r, fin_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (read_end) begin
      fin_v_r <= 1'b1;
    end else if (fin_move) begin
      fin_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_end) begin
      fin_len_r   <= pos_upd;
      fin_bb_r    <= bb_upd;
      fin_bestb_r <= bestb_upd;
      fin_bestl_r <= bestl_upd;
      fin_tot_r   <= tot_upd;
      fin_trim_r  <= tot_upd > tal_upd;
      fin_ovf_r   <= ovf_upd;
    end
  end

  // ---------------------------------------------------------------------------
  // result: close the open block, pick the kept part, apply the length floor
  // ---------------------------------------------------------------------------
  logic [PW-1:0] tail_len, sel_len, sel_begin, keep_len, keep_start;
  logic          short_read;
  rqbt_pkg::out_item_t res;
  rqbt_pkg::out_item_t out_data_r;

  always_comb begin
    tail_len = (fin_len_r >= fin_bb_r) ? fin_len_r - fin_bb_r : '0;
    // tail wins only when strictly longer, ties stay with the earlier block
    if (tail_len > fin_bestl_r) begin
      sel_len   = tail_len;
      sel_begin = fin_bb_r;
    end else begin
      sel_len   = fin_bestl_r;
      sel_begin = fin_bestb_r;
    end
    if (fin_trim_r) begin
      keep_len   = sel_len;
      keep_start = (sel_len != '0) ? sel_begin : '0;
    end else begin
      keep_len   = fin_len_r;
      keep_start = '0;
    end
    short_read = CW'(keep_len) < CW'(cfg_min_len_r);
    if (short_read) begin
      keep_len   = '0;
      keep_start = '0;
    end
    res.keep_start    = START_W'(keep_start);
    res.keep_length   = KEEP_W'(keep_len);
    res.was_trimmed   = fin_trim_r;
    res.too_short     = short_read;
    res.read_length   = LEN_W'(fin_len_r);
    res.error_sum     = ESUM_W'(fin_tot_r);
    res.read_overflow = fin_ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // position bounded and the open block never starts past it
  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= PW'(MAX_READ_LEN)) && (bb_r <= pos_r))
    else $error("block start or position out of range");

  // best block lies inside the bases seen so far
  a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, bestb_r} + {1'b0, bestl_r}) <= {1'b0, pos_r})
    else $error("best block reaches past the current position");

  // a read's last base leaves the accumulators empty for the next read
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    read_end |=> (pos_r == '0) && (tot_r == '0) && (bestl_r == '0) && !ovf_r)
    else $error("read state not cleared after last base");

  // a trimmed, kept result lies inside its read
  a_keep_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_v_r && fin_trim_r) |->
      ({1'b0, sel_begin} + {1'b0, sel_len}) <= {1'b0, fin_len_r})
    else $error("kept block outside the read");

endmodule
